FILE: hdl/tti_pkg.sv
// shared types and constants for the thermistor table interpolator
// used by thermistor_table_interpolator and its testbench; no dependencies
package tti_pkg;

	localparam int DEF_ROWS     = 16;
	localparam int DEF_ADC_BITS = 10;
	localparam int CELSIUS_W    = 8;
	localparam int INDEX_W      = 4;

	localparam logic ACT_CONVERT = 1'b0;
	localparam logic ACT_LOAD    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_WALK,
		ST_MUL,
		ST_START,
		ST_DIV,
		ST_DONE
	} tti_state_t;

endpackage

FILE: hdl/thermistor_table_interpolator.sv
// thermistor table interpolator top level: row table memory, walk sequencer
// depends on tti_pkg and tti_div
//
// usage
// one input channel (item_valid / item_stall) carries a word with an action bit.
// a load word writes one table row (reading, celsius) and gives no result; rows at
// or beyond ROWS are ignored. a convert word gives one celsius word on the result
// channel (result_valid / result_stall).
// a convert reads row 0, then the last row, then walks rows from 1 through a
// table memory with a registered read port, one row per cycle. interpolation
// uses a multiply state and the iterative divider, ADC_BITS + 9 steps, which
// then raises a registered done flag.
// a convert at or above row 0 finishes after ST_FIRST, one at or below the last
// row after ST_LAST, an exact match in the walk, and an interpolated one runs
// ST_MUL, ST_START and ST_DIV before ST_DONE; the next word is taken back in
// ST_IDLE. a load leaves the sequencer in ST_IDLE.
// item_stall is high for the whole of a convert.
// the result sits in an output register; a new word is taken while it waits,
// and when the receiver stalls, a second finished convert waits in its last
// state until the register is free.
// reset clears the sequencer and the result valid flag. table contents are
// undefined until loaded; converts must only touch rows that were loaded.
module thermistor_table_interpolator
	import tti_pkg::*;
#(
	parameter int ROWS     = DEF_ROWS,
	parameter int ADC_BITS = DEF_ADC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 action,
	input  logic [ADC_BITS-1:0]  sample,
	input  logic [INDEX_W-1:0]   entry_index,
	input  logic [ADC_BITS-1:0]  entry_reading,
	input  logic [CELSIUS_W-1:0] entry_celsius,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [CELSIUS_W-1:0] celsius
);

	localparam int A  = ADC_BITS;
	localparam int C  = CELSIUS_W;
	localparam int RW = $clog2(ROWS);
	localparam int NW = A + C + 1;

	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

	tti_state_t state_q, state_d;

	logic [A+C-1:0] mem [ROWS];
	logic [A+C-1:0] rdata_q;
	logic [RW-1:0]  rd_addr;
	logic           load_we;
	logic           accept;
	logic [6:0]     idx_ext;

	logic [A-1:0]   sample_q;
	logic [A-1:0]   prev_r_q;
	logic [C-1:0]   prev_c_q;
	logic [A-1:0]   cur_r_q;
	logic [C-1:0]   cur_c_q;
	logic [RW-1:0]  walk_q;
	logic [C-1:0]   res_q;
	logic [NW-1:0]  num_q;
	logic [A-1:0]   den_q;
	logic           result_valid_q;
	logic [C-1:0]   celsius_q;

	logic [A-1:0]   rd_r;
	logic [C-1:0]   rd_c;
	logic           rising;
	logic [C-1:0]   t_abs;
	logic [A-1:0]   x_off;
	logic [A-1:0]   d_span;
	logic [A+C-1:0] prod;
	logic [NW-1:0]  quotient;
	logic [C-1:0]   q_clamp;
	logic           div_start;
	logic           div_done;
	logic           out_free;

	assign accept   = item_valid && !item_stall;
	assign idx_ext  = {{(7 - INDEX_W){1'b0}}, entry_index};
	assign rd_r     = rdata_q[A+C-1:C];
	assign rd_c     = rdata_q[C-1:0];
	assign out_free = !result_valid_q || !result_stall;

	assign rising = cur_c_q >= prev_c_q;
	assign t_abs  = rising ? (cur_c_q - prev_c_q) : (prev_c_q - cur_c_q);
	assign x_off  = sample_q - cur_r_q;
	assign d_span = prev_r_q - cur_r_q;
	assign prod   = x_off * t_abs;

	assign q_clamp = (quotient > NW'(t_abs)) ? t_abs : quotient[C-1:0];

	// row table
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[idx_ext[RW-1:0]] <= {entry_reading, entry_celsius};
		end
		rdata_q <= mem[rd_addr];
	end

	tti_div #(
		.NW(NW),
		.DW(A)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_q),
		.divisor  (den_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && action == ACT_CONVERT) begin
					state_d = ST_FIRST;
				end
			end
			ST_FIRST: begin
				state_d = (sample_q >= rd_r) ? ST_DONE : ST_LAST;
			end
			ST_LAST: begin
				state_d = (sample_q <= rd_r) ? ST_DONE : ST_WALK;
			end
			ST_WALK: begin
				priority if (sample_q == rd_r) begin
					state_d = ST_DONE;
				end else if (sample_q > rd_r) begin
					state_d = (prev_r_q <= rd_r) ? ST_DONE : ST_MUL;
				end else if (walk_q == LAST_ROW) begin
					state_d = ST_DONE;
				end
			end
			ST_MUL:   state_d = ST_START;
			ST_START: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_stall = 1'b1;
		load_we    = 1'b0;
		div_start  = 1'b0;
		rd_addr    = '0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				load_we    = item_valid && action == ACT_LOAD && idx_ext < 7'(ROWS);
			end
			ST_FIRST: rd_addr = LAST_ROW;
			ST_LAST:  rd_addr = RW'(1);
			ST_WALK:  rd_addr = walk_q + RW'(1);
			ST_START: div_start = 1'b1;
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			celsius_q <= res_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					sample_q <= sample;
				end
			end
			ST_FIRST: begin
				res_q    <= rd_c;
				prev_r_q <= rd_r;
				prev_c_q <= rd_c;
			end
			ST_LAST: begin
				res_q  <= rd_c;
				walk_q <= RW'(1);
			end
			ST_WALK: begin
				res_q   <= rd_c;
				cur_r_q <= rd_r;
				cur_c_q <= rd_c;
				walk_q  <= walk_q + RW'(1);
				// once the walk stops, the row above stays for interpolation
				if (sample_q < rd_r) begin
					prev_r_q <= rd_r;
					prev_c_q <= rd_c;
				end
			end
			ST_MUL: begin
				num_q <= {1'b0, prod} + NW'(d_span >> 1);
				den_q <= d_span;
			end
			ST_DIV: begin
				if (div_done) begin
					res_q <= rising ? (cur_c_q - q_clamp) : (cur_c_q + q_clamp);
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign celsius      = celsius_q;

`ifndef SYNTHESIS
	a_convert_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_CONVERT |=> state_q == ST_FIRST)
		else $error("convert word did not start a table walk");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_LOAD |=> state_q == ST_IDLE)
		else $error("load word left the idle state");

	a_walk_not_row0: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> walk_q != '0)
		else $error("row walk pointed at row 0");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a finished convert");
`endif

endmodule

FILE: hdl/tti_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module tti_div #(
	parameter int NW = 19,
	parameter int DW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [NW-1:0] quotient,
	output logic          done
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign quotient = num_q;
	assign done     = done_q;

endmodule

FILE: sim/thermistor_table_interpolator_test.sv
`timescale 1ns / 1ps
// self-checking testbench for thermistor_table_interpolator, needs tti_pkg: table loads,
// directed and random conversions, checked against typed-in values or its own table walk
module thermistor_table_interpolator_test;
	import tti_pkg::*;

	localparam int TAB_ROWS = DEF_ROWS;
	localparam int ADC_W    = DEF_ADC_BITS;
	localparam int ADC_MAX  = (1 << ADC_W) - 1;
	localparam int ITEM_TARGET = 1700;
	localparam int PLAN_LEN = 26;

	typedef struct packed {
		logic                 act;
		logic [ADC_W-1:0]     smp;
		logic [INDEX_W-1:0]   idx;
		logic [ADC_W-1:0]     rd;
		logic [CELSIUS_W-1:0] cel;
		logic                 known;
		logic [CELSIUS_W-1:0] lit;
	} stim_row_t;

	// rows 0..15 hold readings 1023 - 68*i (last row 0) and temperatures 17*i
	localparam stim_row_t PLAN [0:PLAN_LEN-1] = '{
		'{ACT_LOAD, 10'd0, 4'd0, 10'd1023, 8'd0, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd1, 10'd955, 8'd17, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd2, 10'd887, 8'd34, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd3, 10'd819, 8'd51, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd4, 10'd751, 8'd68, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd5, 10'd683, 8'd85, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd6, 10'd615, 8'd102, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd7, 10'd547, 8'd119, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd8, 10'd479, 8'd136, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd9, 10'd411, 8'd153, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd10, 10'd343, 8'd170, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd11, 10'd275, 8'd187, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd12, 10'd207, 8'd204, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd13, 10'd139, 8'd221, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd0, 4'd14, 10'd71, 8'd238, 1'b0, 8'd0},
		'{ACT_LOAD, 10'd1023, 4'd15, 10'd0, 8'd255, 1'b0, 8'd0},
		// at or above row 0, at or below the last row, exact match, then interpolated samples
		'{ACT_CONVERT, 10'd1023, 4'd15, 10'd1023, 8'd255, 1'b1, 8'd0},
		'{ACT_CONVERT, 10'd0, 4'd0, 10'd0, 8'd0, 1'b1, 8'd255},
		'{ACT_CONVERT, 10'd683, 4'd9, 10'd512, 8'd128, 1'b1, 8'd85},
		'{ACT_CONVERT, 10'd1022, 4'd0, 10'd0, 8'd0, 1'b0, 8'd0},
		'{ACT_CONVERT, 10'd1, 4'd0, 10'd0, 8'd0, 1'b0, 8'd0},
		'{ACT_CONVERT, 10'd700, 4'd0, 10'd0, 8'd0, 1'b0, 8'd0},
		// falling temperature between rows 3 and 4
		'{ACT_LOAD, 10'd800, 4'd4, 10'd751, 8'd20, 1'b0, 8'd0},
		'{ACT_CONVERT, 10'd800, 4'd0, 10'd0, 8'd0, 1'b0, 8'd0},
		// row 7 out of order
		'{ACT_LOAD, 10'd500, 4'd7, 10'd900, 8'd119, 1'b0, 8'd0},
		'{ACT_CONVERT, 10'd500, 4'd0, 10'd0, 8'd0, 1'b0, 8'd0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic                 action = ACT_CONVERT;
	logic [ADC_W-1:0]     sample = '0;
	logic [INDEX_W-1:0]   entry_index = '0;
	logic [ADC_W-1:0]     entry_reading = '0;
	logic [CELSIUS_W-1:0] entry_celsius = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [CELSIUS_W-1:0] celsius;

	// a typed-in expectation travels with its word
	logic                 lit_known = 1'b0;
	logic [CELSIUS_W-1:0] lit_celsius = '0;

	logic [ADC_W-1:0]     reading_tab [TAB_ROWS];
	logic [CELSIUS_W-1:0] celsius_tab [TAB_ROWS];
	logic [CELSIUS_W-1:0] celsius_due [$];
	int                   errors = 0;
	int                   sent = 0;
	bit                   steady = 1'b0;

	thermistor_table_interpolator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.action        (action),
		.sample        (sample),
		.entry_index   (entry_index),
		.entry_reading (entry_reading),
		.entry_celsius (entry_celsius),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.celsius       (celsius)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL thermistor_table_interpolator");
		$finish;
	end

	function automatic logic [CELSIUS_W-1:0] predict_celsius(logic [ADC_W-1:0] s);
		int hi, lo, prev_t, cur_t, d, x, t, q, i;
		if (s >= reading_tab[0])
			return celsius_tab[0];
		if (s <= reading_tab[TAB_ROWS-1])
			return celsius_tab[TAB_ROWS-1];
		for (i = 1; i < TAB_ROWS; i++) begin
			if (s == reading_tab[i])
				return celsius_tab[i];
			if (s > reading_tab[i]) begin
				hi = reading_tab[i-1];
				lo = reading_tab[i];
				prev_t = celsius_tab[i-1];
				cur_t = celsius_tab[i];
				if (hi <= lo)
					return CELSIUS_W'(cur_t);
				d = hi - lo;
				x = s - lo;
				t = (cur_t >= prev_t) ? cur_t - prev_t : prev_t - cur_t;
				q = (x * t + d / 2) / d;
				if (q > t)
					q = t;
				return (cur_t >= prev_t) ? CELSIUS_W'(cur_t - q) : CELSIUS_W'(cur_t + q);
			end
		end
		return celsius_tab[TAB_ROWS-1];
	endfunction

	always @(posedge clk) begin : check_words
		logic [CELSIUS_W-1:0] want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (celsius_due.size() == 0) begin
					errors++;
					$display("%0t: celsius word with none expected, got %0d", $time, celsius);
				end else begin
					want = celsius_due.pop_front();
					if (celsius !== want) begin
						errors++;
						$display("%0t: celsius mismatch, expected %0d, got %0d",
							$time, want, celsius);
					end
				end
			end
			if (item_valid && !item_stall) begin
				if (action == ACT_LOAD) begin
					if (entry_index < TAB_ROWS) begin
						reading_tab[entry_index] = entry_reading;
						celsius_tab[entry_index] = entry_celsius;
					end
				end else begin
					celsius_due.push_back(lit_known ? lit_celsius : predict_celsius(sample));
				end
			end
		end
	end

	always @(negedge clk) begin
		result_stall <= !steady && ($urandom_range(0, 99) < 33);
	end

	task automatic send_word(logic act, logic [ADC_W-1:0] smp, logic [INDEX_W-1:0] idx,
			logic [ADC_W-1:0] rd, logic [CELSIUS_W-1:0] cel, logic known,
			logic [CELSIUS_W-1:0] lit);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 33) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		sample <= smp;
		entry_index <= idx;
		entry_reading <= rd;
		entry_celsius <= cel;
		lit_known <= known;
		lit_celsius <= lit;
		do @(posedge clk); while (!(item_valid && !item_stall));
		sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (celsius_due.size() != 0)
			@(negedge clk);
	endtask

	// mostly falling readings with rising temperatures, some falling temperatures,
	// some rows in no order at all
	task automatic load_random_table();
		int rd [TAB_ROWS];
		int cel [TAB_ROWS];
		int kind, i, room, start, k;
		kind = $urandom_range(0, 19);
		rd[0] = ADC_MAX - $urandom_range(0, 60);
		cel[0] = $urandom_range(0, 30);
		for (i = 1; i < TAB_ROWS; i++) begin
			room = rd[i-1] / (TAB_ROWS - i);
			rd[i] = rd[i-1] - $urandom_range(0, 2 * room);
			if (rd[i] < 0)
				rd[i] = 0;
			room = (255 - cel[i-1]) / (TAB_ROWS - i);
			cel[i] = cel[i-1] + $urandom_range(0, 2 * room);
			if (cel[i] > 255)
				cel[i] = 255;
		end
		if ($urandom_range(0, 3) == 0) begin
			rd[TAB_ROWS-1] = 0;
			cel[TAB_ROWS-1] = 255;
		end
		start = $urandom_range(0, TAB_ROWS - 1);
		for (i = 0; i < TAB_ROWS; i++) begin
			k = (i + start) % TAB_ROWS;
			if (kind >= 17) begin
				rd[k] = $urandom_range(0, ADC_MAX);
				cel[k] = $urandom_range(0, 255);
			end else if (kind >= 14) begin
				cel[k] = 255 - cel[k];
			end
			send_word(ACT_LOAD, ADC_W'($urandom_range(0, ADC_MAX)), INDEX_W'(k),
				ADC_W'(rd[k]), CELSIUS_W'(cel[k]), 1'b0, '0);
		end
	endtask

	task automatic send_convert();
		int v;
		case ($urandom_range(0, 2))
			0: v = $urandom_range(0, ADC_MAX);
			1: v = reading_tab[$urandom_range(0, TAB_ROWS - 1)];
			default: begin
				v = int'(reading_tab[$urandom_range(0, TAB_ROWS - 1)]) + $urandom_range(0, 2) - 1;
				if (v < 0)
					v = 0;
				if (v > ADC_MAX)
					v = ADC_MAX;
			end
		endcase
		send_word(ACT_CONVERT, ADC_W'(v), INDEX_W'($urandom_range(0, TAB_ROWS - 1)),
			ADC_W'($urandom_range(0, ADC_MAX)), CELSIUS_W'($urandom_range(0, 255)),
			1'b0, '0);
	endtask

	initial begin : stimulus
		int n, phase, i;
		for (i = 0; i < TAB_ROWS; i++) begin
			reading_tab[i] = '0;
			celsius_tab[i] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < PLAN_LEN; i++)
			send_word(PLAN[i].act, PLAN[i].smp, PLAN[i].idx, PLAN[i].rd, PLAN[i].cel,
				PLAN[i].known, PLAN[i].lit);
		wait_drained();

		phase = 0;
		while (sent < ITEM_TARGET) begin
			steady = (phase == 4 || phase == 5);
			load_random_table();
			n = $urandom_range(40, 120);
			repeat (n) begin
				// an occasional reload of one row keeps the table moving
				if ($urandom_range(0, 9) == 0)
					send_word(ACT_LOAD, ADC_W'($urandom_range(0, ADC_MAX)),
						INDEX_W'($urandom_range(0, TAB_ROWS - 1)),
						ADC_W'($urandom_range(0, ADC_MAX)),
						CELSIUS_W'($urandom_range(0, 255)), 1'b0, '0);
				else
					send_convert();
			end
			if (phase == 1 || $urandom_range(0, 3) == 0)
				wait_drained();
			phase++;
		end
		steady = 1'b0;

		wait_drained();
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("PASS thermistor_table_interpolator");
		else
			$display("FAIL thermistor_table_interpolator");
		$finish;
	end

endmodule
